// ----- rtl/core/sorted_free_record_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sorted free record allocator
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_FREE_RECORD_ALLOCATOR_ASSERT_SVH
`define SORTED_FREE_RECORD_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SFRA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfra assertion failed");
// next-cycle implication
`define SFRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfra assertion failed");
`else
`define SFRA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SFRA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/sfra_pkg.sv -----
// ----------------------------------------------------------------------------
// sfra_pkg
// Shared constants, codes and control/status types of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package sfra_pkg;

    // default number of free list entries
    localparam int CAPACITY_DEFAULT = 64;

    // command codes
    localparam logic [1:0] CMD_ALLOCATE = 2'd0;
    localparam logic [1:0] CMD_RELEASE  = 2'd1;
    localparam logic [1:0] CMD_PEEK     = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // peek result on an empty set
    localparam logic [15:0] EMPTY_MARK = 16'hFFFF;

    // controller to datapath commands
    typedef struct packed {
        logic init_wr;   // write the reset entry
        logic load;      // capture a transfer
        logic rd_first;  // read smallest entry
        logic rd_last;   // read largest entry
        logic rd_mid;    // read search probe
        logic probe;     // narrow search window
        logic rd_shift;  // read entry idx-1
        logic shift_wr;  // write it to idx
        logic finish;    // commit and load output
    } sfra_ctrl_t;

    // datapath to controller status
    typedef struct packed {
        logic count_zero;
        logic search_open;
        logic dup;
        logic full;
        logic shift_more;
        logic shift_last;
        logic out_free;
    } sfra_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/sfra_datapath.sv -----
// ----------------------------------------------------------------------------
// sfra_datapath
// Circular sorted store, search window, shift counter and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_free_record_allocator_assert.svh"

module sfra_datapath
    import sfra_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire sfra_ctrl_t  ctrl,
    input  wire logic [1:0]  command,
    input  wire logic [15:0] record_number,
    input  wire logic        out_ready,
    output sfra_stat_t       stat,
    output logic             out_valid,
    output logic [15:0]      result_number,
    output logic [1:0]       status,
    output logic [6:0]       entries_held
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    // logical position to physical address, relative to head
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] k);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(k);
        if (sum >= SW'(CAPACITY))
        begin
            sum = sum - SW'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    logic [15:0]   mem [CAPACITY];
    logic [15:0]   rdata_reg;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    cmd_reg;
    logic [15:0]   num_reg;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] idx_reg;
    logic          dup_reg, dup_next;
    logic          out_valid_reg, out_valid_next;
    logic [15:0]   result_reg;
    logic [1:0]    status_reg;
    logic [6:0]    held_reg;

    logic [CW-1:0] mid;
    logic          re, we;
    logic [AW-1:0] raddr, waddr;
    logic [15:0]   wdata;

    // finish results
    logic [15:0]   fin_result;
    logic [1:0]    fin_status;
    logic [CW-1:0] fin_count;
    logic [AW-1:0] fin_head;
    logic          fin_wr;
    logic [AW-1:0] fin_addr;
    logic [15:0]   fin_data;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // status to controller
    assign stat.count_zero  = (count_reg == '0);
    assign stat.search_open = (lo_reg < hi_reg);
    assign stat.dup         = dup_reg;
    assign stat.full        = (count_reg >= CW'(CAPACITY));
    assign stat.shift_more  = (idx_reg > lo_reg);
    assign stat.shift_last  = (idx_reg == lo_reg + CW'(1));
    assign stat.out_free    = !out_valid_reg || out_ready;

    // commit values per command
    always_comb
    begin
        fin_result = 16'd0;
        fin_status = ST_OK;
        fin_count  = count_reg;
        fin_head   = head_reg;
        fin_wr     = 1'b0;
        fin_addr   = phys(head_reg, '0);
        fin_data   = 16'd0;
        case (cmd_reg)
            CMD_ALLOCATE:
            begin
                if (count_reg == '0)
                begin
                    fin_status = ST_EMPTY;
                    fin_count  = CW'(1);
                    fin_wr     = 1'b1;
                end
                else
                begin
                    fin_result = rdata_reg;
                    if (count_reg == CW'(1))
                    begin
                        // set would empty: refill with the next number
                        fin_wr   = 1'b1;
                        fin_data = rdata_reg + 16'd1;
                    end
                    else
                    begin
                        fin_head  = phys(head_reg, CW'(1));
                        fin_count = count_reg - CW'(1);
                    end
                end
            end
            CMD_RELEASE:
            begin
                if (dup_reg)
                begin
                    fin_status = ST_DUPLICATE;
                end
                else if (count_reg >= CW'(CAPACITY))
                begin
                    fin_status = ST_FULL;
                end
                else
                begin
                    fin_wr    = 1'b1;
                    fin_addr  = phys(head_reg, lo_reg);
                    fin_data  = num_reg;
                    fin_count = count_reg + CW'(1);
                end
            end
            CMD_PEEK:
            begin
                if (count_reg == '0)
                begin
                    fin_result = EMPTY_MARK;
                    fin_status = ST_EMPTY;
                end
                else
                begin
                    fin_result = rdata_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // memory port selection
    always_comb
    begin
        re    = ctrl.rd_first || ctrl.rd_last || ctrl.rd_mid || ctrl.rd_shift;
        raddr = phys(head_reg, '0);
        if (ctrl.rd_last)
        begin
            raddr = phys(head_reg, count_reg - CW'(1));
        end
        else if (ctrl.rd_mid)
        begin
            raddr = phys(head_reg, mid);
        end
        else if (ctrl.rd_shift)
        begin
            raddr = phys(head_reg, idx_reg - CW'(1));
        end

        we    = 1'b0;
        waddr = phys(head_reg, '0);
        wdata = 16'd0;
        if (ctrl.init_wr)
        begin
            we = 1'b1;
        end
        else if (ctrl.shift_wr)
        begin
            we    = 1'b1;
            waddr = phys(head_reg, idx_reg);
            wdata = rdata_reg;
        end
        else if (ctrl.finish && fin_wr)
        begin
            we    = 1'b1;
            waddr = fin_addr;
            wdata = fin_data;
        end
    end

    // store
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // search window update
    always_comb
    begin
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        dup_next = dup_reg;
        if (ctrl.load)
        begin
            lo_next  = '0;
            hi_next  = count_reg;
            dup_next = 1'b0;
        end
        else if (ctrl.probe)
        begin
            if (rdata_reg < num_reg)
            begin
                lo_next = mid + CW'(1);
            end
            else
            begin
                hi_next = mid;
            end
            if (rdata_reg == num_reg)
            begin
                dup_next = 1'b1;
            end
        end
    end

    assign head_next      = ctrl.finish ? fin_head : head_reg;
    assign count_next     = ctrl.finish ? fin_count : count_reg;
    assign out_valid_next = ctrl.finish ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= CW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and output payload
    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        dup_reg <= dup_next;
        if (ctrl.load)
        begin
            cmd_reg <= command;
            num_reg <= record_number;
            idx_reg <= count_reg;
        end
        else if (ctrl.shift_wr)
        begin
            idx_reg <= idx_reg - CW'(1);
        end
        if (ctrl.finish)
        begin
            result_reg <= fin_result;
            status_reg <= fin_status;
            held_reg   <= 7'(fin_count);
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_number = result_reg;
    assign status        = status_reg;
    assign entries_held  = held_reg;

    `SFRA_ASSERT_IMPLY(a_count_range, clk, rst_n, 1'b1, (count_reg != '0) && (count_reg <= CW'(CAPACITY)))
    `SFRA_ASSERT_NEXT(a_finish_shows, clk, rst_n, ctrl.finish, out_valid_reg)
    `SFRA_ASSERT_IMPLY(a_shift_bound, clk, rst_n, ctrl.shift_wr, idx_reg > lo_reg)

endmodule

`default_nettype wire

// ----- rtl/core/sfra_controller.sv -----
// ----------------------------------------------------------------------------
// sfra_controller
// Sequences the initial write, and the read, binary search, tail shift and commit that each command needs.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_free_record_allocator_assert.svh"

module sfra_controller
    import sfra_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] command,
    input  wire sfra_stat_t stat,
    output logic            in_ready,
    output sfra_ctrl_t      ctrl
);

    typedef enum logic [6:0] {
        S_INIT     = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_SEARCH   = 7'b0000100,
        S_PROBE    = 7'b0001000,
        S_SHIFT_RD = 7'b0010000,
        S_SHIFT_WR = 7'b0100000,
        S_FINISH   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                ctrl.init_wr = 1'b1;
                state_next   = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load = 1'b1;
                    unique case (command)
                        CMD_ALLOCATE:
                        begin
                            ctrl.rd_first = !stat.count_zero;
                            state_next    = S_FINISH;
                        end
                        CMD_PEEK:
                        begin
                            ctrl.rd_last = !stat.count_zero;
                            state_next   = S_FINISH;
                        end
                        CMD_RELEASE:
                        begin
                            state_next = S_SEARCH;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (stat.search_open)
                begin
                    ctrl.rd_mid = 1'b1;
                    state_next  = S_PROBE;
                end
                else if (stat.dup || stat.full || !stat.shift_more)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SHIFT_RD;
                end
            end
            S_PROBE:
            begin
                ctrl.probe = 1'b1;
                state_next = S_SEARCH;
            end
            S_SHIFT_RD:
            begin
                ctrl.rd_shift = 1'b1;
                state_next    = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                ctrl.shift_wr = 1'b1;
                state_next    = stat.shift_last ? S_FINISH : S_SHIFT_RD;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `SFRA_ASSERT_NEXT(a_finish_to_idle, clk, rst_n, (state_reg == S_FINISH) && stat.out_free, in_ready)
    `SFRA_ASSERT_IMPLY(a_shift_has_room, clk, rst_n, state_reg == S_SHIFT_RD, !stat.full && !stat.dup)
    `SFRA_ASSERT_IMPLY(a_ready_only_idle, clk, rst_n, in_ready, state_reg == S_IDLE)

endmodule

`default_nettype wire

// ----- rtl/core/sorted_free_record_allocator.sv -----
// ----------------------------------------------------------------------------
// sorted_free_record_allocator
// Ascending duplicate-free free list of 16-bit record numbers.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | command, record_number
//  out     | output    | out_valid / out_ready | result_number, status, entries_held
//
// Allocate and peek accept with one store read, then commit. Release accepts,
// runs the binary search (a read and a probe per step, about log2 of the
// count steps), makes a closing search check, moves each entry above the
// insert point by a read and a write, then commits.
// After reset the init state writes the initial entry before in_ready rises.
// A new transfer is taken while a result waits; commit stalls on out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_free_record_allocator
    import sfra_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [15:0] record_number,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      result_number,
    output logic [1:0]       status,
    output logic [6:0]       entries_held
);

    sfra_ctrl_t ctrl;
    sfra_stat_t stat;

    // sequencer
    sfra_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .stat     (stat),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    // store and registers
    sfra_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .command       (command),
        .record_number (record_number),
        .out_ready     (out_ready),
        .stat          (stat),
        .out_valid     (out_valid),
        .result_number (result_number),
        .status        (status),
        .entries_held  (entries_held)
    );

endmodule

`default_nettype wire
